>>> sv/rrf_pkg.sv
package rrf_pkg;

    // Field and register widths
    localparam int COORD_W    = 24;
    localparam int BYTE_W     = 8;
    localparam int ZONE_REG_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 120;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 8;
    localparam int M_TUSER_W  = 1;

    // Edge bounds: wide enough for a 25-bit edge sum plus or minus one unit,
    // and for a pixel position of up to 9 index bits and 16 fraction bits
    localparam int BOUND_W = 27;

    localparam int QUEUE_DEPTH = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND  = 2'd2;

    localparam logic [ZONE_REG_W-1:0] ZONE_RESET       = 9'd1;
    localparam logic [BYTE_W-1:0]     BACKGROUND_RESET = 8'd32;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_OUTLINE = 2'd1,
        CMD_FILL    = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    // Work handed from the front end to the back end
    typedef enum logic [2:0] {
        JOB_CLEAR   = 3'd0,
        JOB_OUTLINE = 3'd1,
        JOB_FILL    = 3'd2,
        JOB_READ    = 3'd3,
        JOB_REPORT  = 3'd4
    } job_kind_t;

    typedef struct packed {
        job_kind_t                  kind;
        logic [BYTE_W-1:0]          paint;
        logic [BYTE_W-1:0]          read_col;
        logic [BYTE_W-1:0]          read_row;
        logic signed [BOUND_W-1:0]  xl;
        logic signed [BOUND_W-1:0]  xr;
        logic signed [BOUND_W-1:0]  xl1;
        logic signed [BOUND_W-1:0]  xr1;
        logic signed [BOUND_W-1:0]  yl;
        logic signed [BOUND_W-1:0]  yr;
        logic signed [BOUND_W-1:0]  yl1;
        logic signed [BOUND_W-1:0]  yr1;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Bits of a pixel index for a given side length
    function automatic int side_bits(input int max_side);
        return (max_side > 1) ? $clog2(max_side) : 1;
    endfunction

endpackage

>>> sv/rrf_front.sv
module rrf_front import rrf_pkg::*; #(
    parameter int MAX_SIDE      = 256,
    parameter int FRACTION_BITS = 8,
    localparam int CW = side_bits(MAX_SIDE),
    localparam int ZW = CW + 1
) (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // corner_x, corner_y, rect_width, rect_height, paint_byte, read_column, read_row
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic [ZW-1:0]        zone_w,
    input  logic [ZW-1:0]        zone_h,
    input  q_stat_t              q_stat,
    output logic                 push,
    output job_t                 push_job
);

    localparam logic signed [BOUND_W-1:0] UNIT = BOUND_W'(1 << FRACTION_BITS);

    cmd_t                      cmd;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] rw;
    logic signed [COORD_W-1:0] rh;
    logic                      size_ok;
    logic                      rd_out;

    assign cmd = cmd_t'(s_tuser);
    assign cx  = s_tdata[23:0];
    assign cy  = s_tdata[47:24];
    assign rw  = s_tdata[71:48];
    assign rh  = s_tdata[95:72];

    assign size_ok = (rw > 0) && (rh > 0);
    assign rd_out  = (32'(s_tdata[111:104]) >= 32'(zone_w))
                  || (32'(s_tdata[119:112]) >= 32'(zone_h));

    // Take a transaction whenever the queue has room
    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    // Classify the command and precompute the edge bounds
    always_comb begin
        push_job          = '0;
        push_job.paint    = s_tdata[103:96];
        push_job.read_col = s_tdata[111:104];
        push_job.read_row = s_tdata[119:112];
        push_job.xl       = BOUND_W'(cx);
        push_job.xr       = BOUND_W'(cx) + BOUND_W'(rw);
        push_job.xl1      = BOUND_W'(cx) + UNIT;
        push_job.xr1      = push_job.xr - UNIT;
        push_job.yl       = BOUND_W'(cy);
        push_job.yr       = BOUND_W'(cy) + BOUND_W'(rh);
        push_job.yl1      = BOUND_W'(cy) + UNIT;
        push_job.yr1      = push_job.yr - UNIT;
        case (cmd)
            CMD_CLEAR:   push_job.kind = JOB_CLEAR;
            CMD_OUTLINE: push_job.kind = size_ok ? JOB_OUTLINE : JOB_REPORT;
            CMD_FILL:    push_job.kind = size_ok ? JOB_FILL : JOB_REPORT;
            CMD_READ:    push_job.kind = rd_out ? JOB_REPORT : JOB_READ;
            default:     push_job.kind = JOB_REPORT;
        endcase
    end

endmodule

>>> sv/rrf_queue.sv
module rrf_queue import rrf_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head_job,
    output q_stat_t stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_next;

    assign head_next = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
    assign tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);

    always_comb begin
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    // Advance pointers and store pushed work
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                entry_reg[tail_reg] <= push_job;
                tail_reg            <= tail_next;
            end
            if (pop) begin
                head_reg <= head_next;
            end
            count_reg <= count_next;
        end
    end

    assign head_job   = entry_reg[head_reg];
    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

>>> sv/rrf_back.sv
module rrf_back import rrf_pkg::*; #(
    parameter int MAX_SIDE      = 256,
    parameter int FRACTION_BITS = 8,
    localparam int CW = side_bits(MAX_SIDE)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  q_stat_t              q_stat,
    input  job_t                 q_job,
    output logic                 q_pop,
    input  logic [CW-1:0]        last_col,
    input  logic [CW-1:0]        last_row,
    input  logic [BYTE_W-1:0]    background,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pixel_value
    output logic [M_TDATA_W-1:0] m_tdata,
    // error_flag
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam logic [CW-1:0] SIDE_LAST = CW'(MAX_SIDE - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DRAW,
        ST_DONE
    } state_t;

    state_t            state_reg;
    job_t              job_reg;
    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     row_reg;
    logic              m_tvalid_reg;
    logic [BYTE_W-1:0] m_pix_reg;
    logic              m_err_reg;

    logic [BYTE_W-1:0] frame_mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic                      mem_we;
    logic [BYTE_W-1:0]         mem_wdata;
    logic signed [BOUND_W-1:0] px;
    logic signed [BOUND_W-1:0] py;
    logic                      in_x;
    logic                      in_y;
    logic                      edge_x;
    logic                      edge_y;
    logic                      hit;
    logic                      col_end;
    logic                      row_end;
    logic [BYTE_W-1:0]         res_pix;
    logic                      res_err;

    // Pop the next job whenever the sequencer is free
    assign q_pop   = (state_reg == ST_IDLE) && !q_stat.empty;
    assign rd_en   = q_pop && (q_job.kind == JOB_READ);
    assign rd_addr = {CW'(q_job.read_row), CW'(q_job.read_col)};

    // Classify the current pixel against the rectangle edges
    assign px     = BOUND_W'(col_reg) << FRACTION_BITS;
    assign py     = BOUND_W'(row_reg) << FRACTION_BITS;
    assign in_x   = (px >= job_reg.xl) && (px <= job_reg.xr);
    assign in_y   = (py >= job_reg.yl) && (py <= job_reg.yr);
    assign edge_x = (px < job_reg.xl1) || (px > job_reg.xr1);
    assign edge_y = (py < job_reg.yl1) || (py > job_reg.yr1);
    assign hit    = in_x && in_y
                 && ((job_reg.kind == JOB_FILL) || edge_x || edge_y);

    assign mem_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_DRAW) && hit);
    assign mem_wdata = (state_reg == ST_CLEAR) ? background : job_reg.paint;

    // A clear sweeps the whole store, a draw only the zone
    assign col_end = (state_reg == ST_CLEAR) ? (col_reg == SIDE_LAST)
                                             : (col_reg == last_col);
    assign row_end = (state_reg == ST_CLEAR) ? (row_reg == SIDE_LAST)
                                             : (row_reg == last_row);

    assign res_pix = (job_reg.kind == JOB_READ) ? rdata_reg : '0;
    assign res_err = (job_reg.kind == JOB_REPORT);

    // Frame store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[{row_reg, col_reg}] <= mem_wdata;
        end
        if (rd_en) begin
            rdata_reg <= frame_mem[rd_addr];
        end
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Drop a taken result unless a new one is loaded below
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        job_reg <= q_job;
                        col_reg <= '0;
                        row_reg <= '0;
                        case (q_job.kind)
                            JOB_CLEAR:             state_reg <= ST_CLEAR;
                            JOB_OUTLINE, JOB_FILL: state_reg <= ST_DRAW;
                            default:               state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_CLEAR, ST_DRAW: begin
                    if (col_end) begin
                        col_reg <= '0;
                        if (row_end) begin
                            state_reg <= ST_DONE;
                        end else begin
                            row_reg <= row_reg + CW'(1);
                        end
                    end else begin
                        col_reg <= col_reg + CW'(1);
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_pix_reg    <= res_pix;
                        m_err_reg    <= res_err;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_pix_reg;
    assign m_tuser  = m_err_reg;

endmodule

>>> sv/rectangle_raster_fill_core.sv
// Rectangle rasterizer over a byte-per-pixel frame store of MAX_SIDE x MAX_SIDE.
// Input stream (s_): s_tuser carries the command (clear, outline, fill, read),
// s_tdata the rectangle corner and size in signed fixed point, the paint byte
// and the pixel position of a read. Output stream (m_): one transaction per
// command, m_tdata the pixel read (zero otherwise), m_tuser the error flag
// (nonpositive draw size, read outside the zone).
// Configuration: cfg_we/cfg_addr/cfg_wdata set zone width, zone height and the
// background byte; write them only while the block is idle.
// The sweep writes one pixel per cycle through the single write port of the
// frame store, so that port sets the rate.
// A two-entry command queue sits between the decode stage and the sequencer;
// input transactions are taken while the queue has room, also while a result
// waits on a stalled receiver. The output register holds its result until taken.
// Reset empties the queue and the output register and loads the register
// defaults; the frame store holds garbage until the first clear.
module rectangle_raster_fill_core import rrf_pkg::*; #(
    parameter int MAX_SIDE      = 256,
    parameter int FRACTION_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // corner_x, corner_y, rect_width, rect_height, paint_byte, read_column, read_row
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // command
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pixel_value
    output logic [M_TDATA_W-1:0]  m_tdata,
    // error_flag
    output logic [M_TUSER_W-1:0]  m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [ZONE_REG_W-1:0] cfg_wdata
);

    localparam int CW = side_bits(MAX_SIDE);
    localparam int ZW = CW + 1;

    logic [ZONE_REG_W-1:0] zone_w_cfg_reg;
    logic [ZONE_REG_W-1:0] zone_h_cfg_reg;
    logic [BYTE_W-1:0]     bg_reg;
    logic [ZW-1:0]         zone_w;
    logic [ZW-1:0]         zone_h;
    logic [CW-1:0]         last_col;
    logic [CW-1:0]         last_row;

    logic    q_push;
    logic    q_pop;
    job_t    q_push_job;
    job_t    q_head_job;
    q_stat_t q_stat;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_w_cfg_reg <= ZONE_RESET;
            zone_h_cfg_reg <= ZONE_RESET;
            bg_reg         <= BACKGROUND_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_ZONE_WIDTH:  zone_w_cfg_reg <= cfg_wdata;
                CFG_ZONE_HEIGHT: zone_h_cfg_reg <= cfg_wdata;
                CFG_BACKGROUND:  bg_reg         <= cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the zone to 1..MAX_SIDE
    always_comb begin
        if (zone_w_cfg_reg == '0) begin
            zone_w = ZW'(1);
        end else if (32'(zone_w_cfg_reg) > 32'(MAX_SIDE)) begin
            zone_w = ZW'(MAX_SIDE);
        end else begin
            zone_w = ZW'(zone_w_cfg_reg);
        end
        if (zone_h_cfg_reg == '0) begin
            zone_h = ZW'(1);
        end else if (32'(zone_h_cfg_reg) > 32'(MAX_SIDE)) begin
            zone_h = ZW'(MAX_SIDE);
        end else begin
            zone_h = ZW'(zone_h_cfg_reg);
        end
    end

    assign last_col = CW'(zone_w - ZW'(1));
    assign last_row = CW'(zone_h - ZW'(1));

    rrf_front #(
        .MAX_SIDE      (MAX_SIDE),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .zone_w   (zone_w),
        .zone_h   (zone_h),
        .q_stat   (q_stat),
        .push     (q_push),
        .push_job (q_push_job)
    );

    rrf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_push_job),
        .pop      (q_pop),
        .head_job (q_head_job),
        .stat     (q_stat)
    );

    rrf_back #(
        .MAX_SIDE      (MAX_SIDE),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_stat     (q_stat),
        .q_job      (q_head_job),
        .q_pop      (q_pop),
        .last_col   (last_col),
        .last_row   (last_row),
        .background (bg_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

`ifndef SYNTHESIS
    // The sequencer only takes work that is queued
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("job popped from an empty queue");

    // A rejected command never carries pixel data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("error result with nonzero pixel");

    // The queue never reports full and empty at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty");

    // A pop with no push leaves the queue with room
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !q_push) |=> !q_stat.full)
        else $error("queue full after a pop");
`endif

endmodule
